// ----- rtl/serb_pkg.sv -----
// ---------------------------------------------------------------------------
// serb_pkg: shared codes for the sequenced event replay buffer
// Request types, result kinds and the fixed field widths of the ports.
// ---------------------------------------------------------------------------
package serb_pkg;

    // Fixed field widths
    localparam int CFG_W    = 6;
    localparam int DATA_W   = 32;
    localparam int CURSOR_W = 64;

    // Request types
    localparam logic REQ_PUBLISH = 1'b0;
    localparam logic REQ_REPLAY  = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PUBLISH = 2'd0,
        KIND_EVENT   = 2'd1,
        KIND_EMPTY   = 2'd2
    } t_kind;

endpackage

// ----- rtl/serb_ring.sv -----
// ---------------------------------------------------------------------------
// serb_ring: event history ring storage
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module serb_ring #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write the published payload
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read every cycle into the output register
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/sequenced_event_replay_buffer.sv -----
// ---------------------------------------------------------------------------
// sequenced_event_replay_buffer: bounded event history with 64-bit cursors
// Publish stores a payload under the next cursor and trims to capacity;
// replay returns every held event above a cursor, oldest first.
// ---------------------------------------------------------------------------
// Publish: result in the cycle after the request; busy stays low, one publish per cycle.
// Replay: one scan step per held entry through the single compare and ring read port,
//   then a flush step, before the next request is taken.
// Replay results leave as the scan finds them, the last during the cycle busy falls.
// Reset (synchronous, active low) empties the history, zeroes the cursors and
//   sets capacity to 1; results cannot be stalled by the receiver.
module sequenced_event_replay_buffer
    import serb_pkg::*;
#(
    parameter int DEPTH        = 32,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic                i_req_type,
    input  logic [DATA_W-1:0]   i_payload,
    input  logic [CURSOR_W-1:0] i_from_cursor,
    output logic                o_valid,
    output logic [1:0]          o_result_kind,
    output logic [CURSOR_W-1:0] o_event_cursor,
    output logic [DATA_W-1:0]   o_event_data,
    output logic                o_complete,
    output logic [CURSOR_W-1:0] o_newest_cursor,
    output logic                o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_head;
    logic [CW-1:0]           r_held;
    logic [CW-1:0]           r_cap;
    logic [CURSOR_W-1:0]     r_latest;
    logic [CURSOR_W-1:0]     r_oldest;
    logic [AW-1:0]           r_addr;
    logic [CW-1:0]           r_left;
    logic [CURSOR_W-1:0]     r_cur;
    logic [CURSOR_W-1:0]     r_from;
    logic                    r_cplt;
    logic                    r_pend_vld;
    logic [CURSOR_W-1:0]     r_pend_cur;
    logic [PAYLOAD_BITS-1:0] r_pend_data;
    logic                    r_valid;
    t_kind                   r_kind;
    logic [CURSOR_W-1:0]     r_ocur;
    logic [DATA_W-1:0]       r_odata;
    logic                    r_ocplt;
    logic                    r_olast;

    logic                    accept;
    logic [SW-1:0]           held_inc;
    logic                    trim;
    logic [CURSOR_W-1:0]     n_latest;
    logic [CURSOR_W-1:0]     trim_oldest;
    logic [SW-1:0]           start_sum;
    logic [AW-1:0]           start_slot;
    logic [AW-1:0]           head_inc;
    logic [AW-1:0]           addr_inc;
    logic [AW-1:0]           rd_addr;
    logic [CURSOR_W-1:0]     first_cur;
    logic                    replay_cplt;
    logic [KW-1:0]           cfg_ext;
    logic [CW-1:0]           cap_new;
    logic                    hit;
    logic                    wr_en;
    logic [PAYLOAD_BITS-1:0] pub_data;
    logic [PAYLOAD_BITS-1:0] rd_data;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // Publish: grow the count and trim to capacity in one step
    assign held_inc    = {1'b0, r_held} + SW'(1);
    assign trim        = held_inc > {1'b0, r_cap};
    assign n_latest    = r_latest + 64'd1;
    assign trim_oldest = r_latest + 64'd2 - 64'(r_cap);
    assign head_inc    = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign pub_data    = PAYLOAD_BITS'(i_payload);

    // Replay: oldest held slot and cursor, completeness flag
    assign start_sum  = SW'(r_head) + SW'(DEPTH) - {1'b0, r_held};
    assign start_slot = (start_sum >= SW'(DEPTH)) ? AW'(start_sum - SW'(DEPTH))
                                                  : AW'(start_sum);
    assign first_cur  = r_latest - 64'(r_held) + 64'd1;
    assign replay_cplt = (i_from_cursor == '0) || (r_oldest == '0) ||
                         (i_from_cursor >= r_latest) ||
                         ((i_from_cursor + 64'd1) >= r_oldest);

    // Scan step: advance the ring pointer, compare the cursor
    assign addr_inc = (r_addr == AW'(DEPTH - 1)) ? '0 : r_addr + AW'(1);
    assign hit      = r_cur > r_from;
    assign rd_addr  = (r_state == ST_SCAN) ? addr_inc : start_slot;

    // Clamp the capacity write to 1..DEPTH
    assign cfg_ext = KW'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            cap_new = CW'(1);
        end else if (cfg_ext > KW'(DEPTH)) begin
            cap_new = CW'(DEPTH);
        end else begin
            cap_new = CW'(cfg_ext);
        end
    end

    assign wr_en = accept && (i_req_type == REQ_PUBLISH);

    serb_ring #(
        .DEPTH (DEPTH),
        .WIDTH (PAYLOAD_BITS)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_head),
        .i_wr_data (pub_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer, history state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_head     <= '0;
            r_held     <= '0;
            r_cap      <= CW'(1);
            r_latest   <= '0;
            r_oldest   <= '0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cap <= cap_new;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_req_type == REQ_PUBLISH)) begin
                        r_head   <= head_inc;
                        r_latest <= n_latest;
                        if (trim) begin
                            r_held   <= r_cap;
                            r_oldest <= trim_oldest;
                        end else begin
                            r_held <= CW'(held_inc);
                            if (r_oldest == '0) begin
                                r_oldest <= n_latest;
                            end
                        end
                        r_valid <= 1'b1;
                        r_kind  <= KIND_PUBLISH;
                        r_ocur  <= n_latest;
                        r_odata <= DATA_W'(pub_data);
                        r_ocplt <= 1'b1;
                        r_olast <= 1'b1;
                    end else if (accept) begin
                        r_from     <= i_from_cursor;
                        r_cplt     <= replay_cplt;
                        r_cur      <= first_cur;
                        r_addr     <= start_slot;
                        r_left     <= r_held;
                        r_pend_vld <= 1'b0;
                        r_state    <= (r_held == '0) ? ST_FLUSH : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Hold one hit back so the final one can carry last
                    if (hit) begin
                        if (r_pend_vld) begin
                            r_valid <= 1'b1;
                            r_kind  <= KIND_EVENT;
                            r_ocur  <= r_pend_cur;
                            r_odata <= DATA_W'(r_pend_data);
                            r_ocplt <= r_cplt;
                            r_olast <= 1'b0;
                        end
                        r_pend_vld  <= 1'b1;
                        r_pend_cur  <= r_cur;
                        r_pend_data <= rd_data;
                    end
                    r_cur  <= r_cur + 64'd1;
                    r_addr <= addr_inc;
                    r_left <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    r_valid <= 1'b1;
                    r_ocplt <= r_cplt;
                    r_olast <= 1'b1;
                    if (r_pend_vld) begin
                        r_kind  <= KIND_EVENT;
                        r_ocur  <= r_pend_cur;
                        r_odata <= DATA_W'(r_pend_data);
                    end else begin
                        r_kind  <= KIND_EMPTY;
                        r_ocur  <= '0;
                        r_odata <= '0;
                    end
                    r_pend_vld <= 1'b0;
                    r_state    <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_result_kind   = r_kind;
    assign o_event_cursor  = r_ocur;
    assign o_event_data    = r_odata;
    assign o_complete      = r_ocplt;
    assign o_newest_cursor = r_latest;
    assign o_last          = r_olast;

    // A publish request is acknowledged in the next cycle as a final result
    a_pub_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_PUBLISH)) |=>
            (o_valid && o_last && (o_result_kind == KIND_PUBLISH)))
        else $error("publish request not acknowledged");

    // The final result of a request leaves the sequencer idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == ST_IDLE))
        else $error("final result while sequencer still busy");

    // The held count never exceeds the ring depth or the capacity after publish
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_PUBLISH)) |=>
            ((r_held <= r_cap) && (r_held <= CW'(DEPTH))))
        else $error("held count above capacity after publish");

    // The scan only runs with entries left to visit
    a_scan_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_left != '0))
        else $error("scan with no entries left");

    // An empty replay is a single final result with zero cursor and data
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_EMPTY)) |->
            (o_last && (o_event_cursor == '0) && (o_event_data == '0)))
        else $error("malformed empty replay result");

endmodule

// ----- test/sequenced_event_replay_buffer_tb.sv -----
// ---------------------------------------------------------------------------
// sequenced_event_replay_buffer_tb: self-checking bench for the replay buffer
// Drives publish and replay requests through the start/busy handshake, keeps
// its own copy of the cursor history and checks every result field in order.
// Runs a directed part over the corner cases, then random traffic over
// several capacity settings with random gaps between requests.
// ---------------------------------------------------------------------------
module sequenced_event_replay_buffer_tb;
    import serb_pkg::*;

    localparam int HIST_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 200000;

    // One result as the block should present it
    typedef struct packed {
        t_kind                kind;
        logic [CURSOR_W-1:0]  cursor;
        logic [DATA_W-1:0]    data;
        logic                 complete;
        logic [CURSOR_W-1:0]  newest;
        logic                 last;
    } t_history_result;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata   = '0;
    logic                start         = 1'b0;
    logic                busy;
    logic                i_req_type    = REQ_PUBLISH;
    logic [DATA_W-1:0]   i_payload     = '0;
    logic [CURSOR_W-1:0] i_from_cursor = '0;
    logic                o_valid;
    logic [1:0]          o_result_kind;
    logic [CURSOR_W-1:0] o_event_cursor;
    logic [DATA_W-1:0]   o_event_data;
    logic                o_complete;
    logic [CURSOR_W-1:0] o_newest_cursor;
    logic                o_last;

    // Shadow of the history kept by the block
    logic [DATA_W-1:0]   hist_data [0:HIST_DEPTH-1];
    logic [4:0]          hist_head   = '0;
    int                  hist_count  = 0;
    logic [CURSOR_W-1:0] hist_newest = '0;
    logic [CURSOR_W-1:0] hist_oldest = '0;
    int                  hist_cap    = 1;

    t_history_result     due_results[$];
    t_history_result     arrived;
    int                  error_count = 0;
    int                  cycle_count = 0;

    sequenced_event_replay_buffer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_payload       (i_payload),
        .i_from_cursor   (i_from_cursor),
        .o_valid         (o_valid),
        .o_result_kind   (o_result_kind),
        .o_event_cursor  (o_event_cursor),
        .o_event_data    (o_event_data),
        .o_complete      (o_complete),
        .o_newest_cursor (o_newest_cursor),
        .o_last          (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Apply one accepted request to the shadow history and queue its results
    task automatic run_history(input logic rtype, input logic [DATA_W-1:0] pl,
                               input logic [CURSOR_W-1:0] from);
        t_history_result     r;
        logic [CURSOR_W-1:0] first_cursor;
        logic [CURSOR_W-1:0] cur;
        logic [CURSOR_W-1:0] from_next;
        logic [4:0]          slot;
        logic                whole;
        int                  i;
        bit                  any;

        if (rtype == REQ_PUBLISH) begin
            hist_newest = hist_newest + 64'd1;
            hist_data[hist_head] = pl;
            hist_head = hist_head + 5'd1;
            hist_count++;
            if (hist_oldest == '0)
                hist_oldest = hist_newest;
            // Drop the oldest entries beyond capacity
            while (hist_count > hist_cap) begin
                hist_oldest = hist_newest - 64'(hist_count) + 64'd2;
                hist_count--;
            end
            r = '{KIND_PUBLISH, hist_newest, pl, 1'b1, hist_newest, 1'b1};
            due_results.push_back(r);
        end else begin
            from_next = from + 64'd1;
            whole = (from == '0) || (hist_oldest == '0) || (from >= hist_newest) ||
                    (from_next >= hist_oldest);
            slot = hist_head - 5'(hist_count);
            first_cursor = hist_newest - 64'(hist_count) + 64'd1;
            any = 1'b0;
            // Cursors rise along the ring, so the newest entry closes the replay
            for (i = 0; i < hist_count; i++) begin
                cur = first_cursor + 64'(i);
                if (cur > from) begin
                    r = '{KIND_EVENT, cur, hist_data[slot], whole, hist_newest,
                          (i == hist_count - 1)};
                    due_results.push_back(r);
                    any = 1'b1;
                end
                slot = slot + 5'd1;
            end
            if (!any) begin
                r = '{KIND_EMPTY, '0, '0, whole, hist_newest, 1'b1};
                due_results.push_back(r);
            end
        end
    endtask

    task automatic report_field(input string field, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        error_count++;
    endtask

    // Compare each result with the oldest one outstanding
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (due_results.size() == 0) begin
                $display("%0t: unrequested result, kind %0d cursor 0x%0h", $time,
                         o_result_kind, o_event_cursor);
                error_count++;
            end else begin
                arrived = due_results.pop_front();
                if (o_result_kind !== arrived.kind)
                    report_field("result_kind", arrived.kind, o_result_kind);
                if (o_event_cursor !== arrived.cursor)
                    report_field("event_cursor", arrived.cursor, o_event_cursor);
                if (o_event_data !== arrived.data)
                    report_field("event_data", arrived.data, o_event_data);
                if (o_complete !== arrived.complete)
                    report_field("complete", arrived.complete, o_complete);
                if (o_newest_cursor !== arrived.newest)
                    report_field("newest_cursor", arrived.newest, o_newest_cursor);
                if (o_last !== arrived.last)
                    report_field("last", arrived.last, o_last);
            end
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic rtype, input logic [DATA_W-1:0] pl,
                                input logic [CURSOR_W-1:0] from);
        @(negedge i_clk);
        start         <= 1'b1;
        i_req_type    <= rtype;
        i_payload     <= pl;
        i_from_cursor <= from;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        run_history(rtype, pl, from);
    endtask

    // Idle the request side, with noise on the ignored fields
    task automatic pause_cycles(input int n);
        @(negedge i_clk);
        start         <= 1'b0;
        i_req_type    <= 1'($urandom);
        i_payload     <= $urandom;
        i_from_cursor <= {$urandom, $urandom};
        repeat (n - 1)
            @(negedge i_clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_history();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (3)
            @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        drain_history();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (value == '0)
            hist_cap = 1;
        else if (value > HIST_DEPTH)
            hist_cap = HIST_DEPTH;
        else
            hist_cap = value;
    endtask

    // Replay with nothing ever published, at both ends of the cursor range
    task automatic test_empty_replay();
        send_request(REQ_REPLAY, 32'h0, 64'd0);
        send_request(REQ_REPLAY, 32'hFFFF_FFFF, '1);
    endtask

    // Extreme payloads at reset capacity; the second publish drops the first
    task automatic test_publish_extremes();
        send_request(REQ_PUBLISH, 32'h0, '1);
        send_request(REQ_PUBLISH, 32'hFFFF_FFFF, 64'd0);
        send_request(REQ_REPLAY, 32'h0, 64'd0);
        send_request(REQ_REPLAY, 32'h0, 64'd1);
        send_request(REQ_REPLAY, 32'h0, 64'd2);
    endtask

    // Oversized write saturates; replay over a partly filled history
    task automatic test_capacity_saturate();
        int k;

        write_capacity(6'd63);
        for (k = 0; k < 5; k++)
            send_request(REQ_PUBLISH, $urandom, {$urandom, $urandom});
        send_request(REQ_REPLAY, $urandom, 64'd0);
        send_request(REQ_REPLAY, $urandom, 64'd4);
        send_request(REQ_REPLAY, $urandom, hist_newest);
        send_request(REQ_REPLAY, $urandom, '1);
    endtask

    // Lowered capacity keeps extra entries until the next publish trims them
    task automatic test_capacity_lowered();
        write_capacity(6'd2);
        send_request(REQ_REPLAY, $urandom, 64'd0);
        send_request(REQ_PUBLISH, $urandom, 64'd0);
        send_request(REQ_REPLAY, $urandom, 64'd1);
    endtask

    // A write of zero leaves a capacity of one
    task automatic test_capacity_zero();
        write_capacity(6'd0);
        send_request(REQ_PUBLISH, $urandom, 64'd0);
        send_request(REQ_REPLAY, $urandom, 64'd0);
    endtask

    // Random publish and replay traffic over a series of capacities
    task automatic test_random_traffic();
        int                  phase;
        int                  k;
        int                  pick;
        bit                  steady;
        logic                rtype;
        logic [CFG_W-1:0]    cap_value;
        logic [CURSOR_W-1:0] from;

        for (phase = 0; phase < 9; phase++) begin
            unique case (phase)
                0: cap_value = 6'd32;
                1: cap_value = 6'd1;
                2: cap_value = 6'd63;
                3: cap_value = 6'd0;
                4: cap_value = 6'd33;
                default: cap_value = CFG_W'($urandom_range(63));
            endcase
            write_capacity(cap_value);
            // One phase runs back to back with no gaps at all
            steady = (phase == 5);
            for (k = 0; k < 28; k++) begin
                if (!steady && $urandom_range(99) < 38)
                    pause_cycles($urandom_range(1, 4));
                if (!steady && $urandom_range(99) < 3)
                    drain_history();
                rtype = ($urandom_range(99) < 55) ? REQ_PUBLISH : REQ_REPLAY;
                pick = $urandom_range(9);
                unique case (pick)
                    0: from = '0;
                    1: from = '1;
                    2: from = {$urandom, $urandom};
                    3: from = hist_newest;
                    4: from = hist_newest + 64'($urandom_range(1, 5));
                    default: from = hist_newest - 64'($urandom_range(0, hist_count + 4));
                endcase
                send_request(rtype, $urandom, from);
            end
        end
    endtask

    initial begin
        repeat (8)
            @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_replay();
        test_publish_extremes();
        test_capacity_saturate();
        test_capacity_lowered();
        test_capacity_zero();
        test_random_traffic();

        drain_history();
        repeat (40)
            @(posedge i_clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
